### hdl/xxhash64_stream_macros.svh
// ----------------------------------------------------------------------------
// xxhash64_stream assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef XXHASH64_STREAM_MACROS_SVH
`define XXHASH64_STREAM_MACROS_SVH

// same-cycle implication
`define XXH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define XXH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// Types, primes and helpers shared by the xxHash64 stream modules.
// ----------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    localparam logic [63:0] LANE0_INIT = P1 + P2;
    localparam logic [63:0] LANE1_INIT = P2;
    localparam logic [63:0] LANE2_INIT = 64'd0;
    localparam logic [63:0] LANE3_INIT = 64'd0 - P1;

    localparam logic [3:0] FULL_BYTES = 4'd8;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_item;

    function automatic logic [63:0] f_rotl(input logic [63:0] v, input logic [5:0] s);
        logic [6:0] rs;
        rs = 7'd64 - {1'b0, s};
        return (v << s) | (v >> rs);
    endfunction

endpackage

### hdl/xxh_front.sv
// ----------------------------------------------------------------------------
// xxh_front
// Accepts input beats, normalizes the byte count and queues them (2 deep).
// ----------------------------------------------------------------------------
module xxh_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [63:0]         i_data_word,
    input  logic [3:0]          i_byte_count,
    input  logic                i_last_word,
    output logic                o_avail,
    output xxh_pkg::t_item      o_item,
    input  logic                i_pop
);
    import xxh_pkg::*;

    t_item       r_mem [2];
    logic        r_wr;
    logic        n_wr;
    logic        r_rd;
    logic        n_rd;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_push;
    logic        w_pop;
    t_item       w_item;

    assign o_stall = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && o_avail;

    always_comb begin
        w_item.word   = i_data_word;
        w_item.last   = i_last_word;
        w_item.nbytes = (!i_last_word || (i_byte_count > FULL_BYTES)) ? FULL_BYTES
                                                                       : i_byte_count;
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = w_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

endmodule

### hdl/xxh_mul.sv
// ----------------------------------------------------------------------------
// xxh_mul
// 64x64 multiply modulo 2^64 on one 32x32 multiplier, three partial products in turn.
// ----------------------------------------------------------------------------
module xxh_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    import xxh_pkg::*;

    logic [1:0]  r_step;
    logic [1:0]  n_step;
    logic [63:0] r_acc;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_pp;

    assign o_done = (r_step == 2'd3);
    assign o_prod = r_acc;
    assign w_pp   = w_ma * w_mb;

    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_ma = i_a[31:0];
                w_mb = i_b[31:0];
            end
            2'd1: begin
                w_ma = i_a[31:0];
                w_mb = i_b[63:32];
            end
            default: begin
                w_ma = i_a[63:32];
                w_mb = i_b[31:0];
            end
        endcase
        n_step = i_go ? r_step + 2'd1 : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 2'd0;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == 2'd0) begin
            r_acc <= w_pp;
        end else if (r_step != 2'd3) begin
            r_acc <= {r_acc[63:32] + w_pp[31:0], r_acc[31:0]};
        end
    end

endmodule

### hdl/xxh_core.sv
// ----------------------------------------------------------------------------
// xxh_core
// Sequencer for stripe absorb, merge, tail steps and avalanche.
// ----------------------------------------------------------------------------
`include "xxhash64_stream_macros.svh"

module xxh_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  xxh_pkg::t_item      i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [63:0]         o_hash_value
);
    import xxh_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_ABS_A = 20'h00002,
        S_ABS_B = 20'h00004,
        S_FIN   = 20'h00008,
        S_MRG_A = 20'h00010,
        S_MRG_B = 20'h00020,
        S_MRG_C = 20'h00040,
        S_LEN   = 20'h00080,
        S_TSEL  = 20'h00100,
        S_TW_A  = 20'h00200,
        S_TW_B  = 20'h00400,
        S_TW_C  = 20'h00800,
        S_W4_A  = 20'h01000,
        S_W4_B  = 20'h02000,
        S_BSEL  = 20'h04000,
        S_B_A   = 20'h08000,
        S_B_B   = 20'h10000,
        S_AV_A  = 20'h20000,
        S_AV_B  = 20'h40000,
        S_OUT   = 20'h80000
    } t_state;

    t_state      r_state;
    logic [63:0] r_lane [4];
    logic [63:0] r_buf [3];
    logic [1:0]  r_wis;
    logic        r_seen;
    logic [63:0] r_total;
    logic [63:0] r_word;
    logic        r_last;
    logic [2:0]  r_pn;
    logic [1:0]  r_li;
    logic [1:0]  r_ti;
    logic [2:0]  r_bi;
    logic [63:0] r_h;
    logic [63:0] r_t;
    logic        r_ovalid;
    logic [63:0] r_hash;

    logic        w_go;
    logic [63:0] w_ma;
    logic [63:0] w_mb;
    logic        w_done;
    logic [63:0] w_p;
    logic [1:0]  w_bidx;
    logic [63:0] w_bword;
    logic        w_emit;

    assign o_valid      = r_ovalid;
    assign o_hash_value = r_hash;
    assign o_pop        = (r_state == S_IDLE) && i_avail;
    assign w_emit       = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign w_bidx       = (r_state == S_TW_A) ? r_ti : r_li;
    assign w_bword      = (w_bidx == 2'd3) ? r_word : r_buf[w_bidx];

    always_comb begin
        w_go = 1'b1;
        w_ma = r_h;
        w_mb = P1;
        unique case (r_state)
            S_ABS_A: begin
                w_ma = w_bword;
                w_mb = P2;
            end
            S_MRG_A: begin
                w_ma = r_lane[r_li];
                w_mb = P2;
            end
            S_TW_A: begin
                w_ma = w_bword;
                w_mb = P2;
            end
            S_ABS_B, S_MRG_B, S_TW_B: begin
                w_ma = f_rotl(r_t, 6'd31);
            end
            S_MRG_C: begin
                w_ma = r_h;
            end
            S_TW_C: begin
                w_ma = f_rotl(r_h, 6'd27);
            end
            S_W4_A: begin
                w_ma = {32'd0, r_word[31:0]};
            end
            S_W4_B: begin
                w_ma = f_rotl(r_h, 6'd23);
                w_mb = P2;
            end
            S_B_A: begin
                w_ma = {56'd0, r_word[7:0]};
                w_mb = P5;
            end
            S_B_B: begin
                w_ma = f_rotl(r_h, 6'd11);
            end
            S_AV_A: begin
                w_ma = r_h ^ (r_h >> 33);
                w_mb = P2;
            end
            S_AV_B: begin
                w_ma = r_h ^ (r_h >> 29);
                w_mb = P3;
            end
            default: begin
                w_go = 1'b0;
            end
        endcase
    end

    xxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_done),
        .o_prod  (w_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lane[0] <= LANE0_INIT;
            r_lane[1] <= LANE1_INIT;
            r_lane[2] <= LANE2_INIT;
            r_lane[3] <= LANE3_INIT;
            r_wis     <= 2'd0;
            r_seen    <= 1'b0;
            r_total   <= 64'd0;
            r_li      <= 2'd0;
            r_ti      <= 2'd0;
            r_bi      <= 3'd0;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_total <= r_total + {60'd0, i_item.nbytes};
                        if (i_item.nbytes[3]) begin
                            if (r_wis != 2'd3) begin
                                r_wis   <= r_wis + 2'd1;
                                r_state <= i_item.last ? S_FIN : S_IDLE;
                            end else begin
                                r_li    <= 2'd0;
                                r_state <= S_ABS_A;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_ABS_A: begin
                    if (w_done) begin
                        r_state <= S_ABS_B;
                    end
                end
                S_ABS_B: begin
                    if (w_done) begin
                        r_lane[r_li] <= w_p;
                        r_li         <= r_li + 2'd1;
                        if (r_li == 2'd3) begin
                            r_seen  <= 1'b1;
                            r_wis   <= 2'd0;
                            r_state <= r_last ? S_FIN : S_IDLE;
                        end else begin
                            r_state <= S_ABS_A;
                        end
                    end
                end
                S_FIN: begin
                    r_li    <= 2'd0;
                    r_state <= r_seen ? S_MRG_A : S_LEN;
                end
                S_MRG_A: begin
                    if (w_done) begin
                        r_state <= S_MRG_B;
                    end
                end
                S_MRG_B: begin
                    if (w_done) begin
                        r_state <= S_MRG_C;
                    end
                end
                S_MRG_C: begin
                    if (w_done) begin
                        r_li    <= r_li + 2'd1;
                        r_state <= (r_li == 2'd3) ? S_LEN : S_MRG_A;
                    end
                end
                S_LEN: begin
                    r_ti    <= 2'd0;
                    r_state <= S_TSEL;
                end
                S_TSEL: begin
                    r_bi <= 3'd0;
                    priority if (r_ti != r_wis) begin
                        r_state <= S_TW_A;
                    end else if (r_pn[2]) begin
                        r_state <= S_W4_A;
                    end else begin
                        r_state <= S_BSEL;
                    end
                end
                S_TW_A: begin
                    if (w_done) begin
                        r_state <= S_TW_B;
                    end
                end
                S_TW_B: begin
                    if (w_done) begin
                        r_state <= S_TW_C;
                    end
                end
                S_TW_C: begin
                    if (w_done) begin
                        r_ti    <= r_ti + 2'd1;
                        r_state <= S_TSEL;
                    end
                end
                S_W4_A: begin
                    if (w_done) begin
                        r_state <= S_W4_B;
                    end
                end
                S_W4_B: begin
                    if (w_done) begin
                        r_bi    <= 3'd4;
                        r_state <= S_BSEL;
                    end
                end
                S_BSEL: begin
                    r_state <= (r_bi < r_pn) ? S_B_A : S_AV_A;
                end
                S_B_A: begin
                    if (w_done) begin
                        r_state <= S_B_B;
                    end
                end
                S_B_B: begin
                    if (w_done) begin
                        r_bi    <= r_bi + 3'd1;
                        r_state <= S_BSEL;
                    end
                end
                S_AV_A: begin
                    if (w_done) begin
                        r_state <= S_AV_B;
                    end
                end
                S_AV_B: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_emit) begin
                        r_lane[0] <= LANE0_INIT;
                        r_lane[1] <= LANE1_INIT;
                        r_lane[2] <= LANE2_INIT;
                        r_lane[3] <= LANE3_INIT;
                        r_wis     <= 2'd0;
                        r_seen    <= 1'b0;
                        r_total   <= 64'd0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_item.word;
            r_last <= i_item.last;
            r_pn   <= i_item.nbytes[2:0];
            if (i_item.nbytes[3] && (r_wis != 2'd3)) begin
                r_buf[r_wis] <= i_item.word;
            end
        end
        if (r_state == S_FIN) begin
            r_h <= r_seen ? (f_rotl(r_lane[0], 6'd1) + f_rotl(r_lane[1], 6'd7) +
                             f_rotl(r_lane[2], 6'd12) + f_rotl(r_lane[3], 6'd18))
                          : P5;
        end
        if (r_state == S_LEN) begin
            r_h <= r_h + r_total;
        end
        if (w_done) begin
            unique case (r_state)
                S_ABS_A:                 r_t <= r_lane[r_li] + w_p;
                S_MRG_A, S_TW_A:         r_t <= w_p;
                S_MRG_B, S_TW_B, S_W4_A,
                S_B_A:                   r_h <= r_h ^ w_p;
                S_MRG_C, S_TW_C:         r_h <= w_p + P4;
                S_W4_B: begin
                    r_h    <= w_p + P3;
                    r_word <= r_word >> 32;
                end
                S_B_B: begin
                    r_h    <= w_p;
                    r_word <= r_word >> 8;
                end
                S_AV_A, S_AV_B:          r_h <= w_p;
                default:                 r_t <= r_t;
            endcase
        end
        if (w_emit) begin
            r_hash <= r_h ^ (r_h >> 32);
        end
    end

    `XXH_ASSERT_NXT(a_absorb_clears_wis, (r_state == S_ABS_B) && w_done && (r_li == 2'd3), r_wis == 2'd0 && r_seen)
    `XXH_ASSERT_NXT(a_emit_resets, w_emit, (r_total == 64'd0) && (r_wis == 2'd0) && !r_seen && o_valid)
    `XXH_ASSERT_IMP(a_pop_idle, o_pop, (r_state == S_IDLE) && !w_done)

endmodule

### hdl/xxhash64_stream.sv
// ----------------------------------------------------------------------------
// xxhash64_stream
// Streaming xxHash64 (seed zero) over little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one word per beat with its byte
// count and a last flag; non-last beats always count as eight bytes.
// Output channel: o_valid / i_stall carry one digest per message.
// A two-deep queue sits between the front end and the hash sequencer; a beat
// waits there until the sequencer pops it.
// Every 64-bit product runs on one 32x32 multiplier.
// A word that fills a buffer slot is only stored; the word closing a stripe
// runs eight products, two per lane. The last beat then adds finalization:
// a four-lane merge after any stripe, a step per buffered word, the 4-byte
// step if four or more tail bytes remain, a step per single tail byte, and
// the avalanche.
// The digest waits in the output register while i_stall is high; the core
// holds the next digest until it is taken, while the queue accepts until full.
// Reset (synchronous, active low) empties the queue and restores the lanes.
// ----------------------------------------------------------------------------
module xxhash64_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash_value
);
    import xxh_pkg::*;

    t_item w_item;
    logic  w_avail;
    logic  w_pop;

    xxh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last_word  (i_last_word),
        .o_avail      (w_avail),
        .o_item       (w_item),
        .i_pop        (w_pop)
    );

    xxh_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (w_avail),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash_value (o_hash_value)
    );

endmodule

### bench/xxhash64_stream_test.sv
// ----------------------------------------------------------------------------
// xxhash64_stream_test
// Sends word streams with random gaps and stalls to the xxHash64 stream block.
// A local predictor computes each expected digest, and every digest that
// comes out is compared against it in order.
// ----------------------------------------------------------------------------
module xxhash64_stream_test;
    timeunit 1ns;
    timeprecision 1ps;
    import xxh_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_data_word = '0;
    logic [3:0]  i_byte_count = '0;
    logic        i_last_word = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_hash_value;

    xxhash64_stream u_top (.*);

    always #4 i_clk = ~i_clk;

    logic [63:0] lane [4];
    logic [63:0] held [3];
    int unsigned held_cnt;
    bit          striped;
    logic [63:0] msg_len;
    logic [63:0] digest_q [$];
    int unsigned err_cnt = 0;
    longint unsigned cyc = 0;
    int unsigned hold_cycles = 0;
    int unsigned words_sent = 0;

    function automatic logic [63:0] rotl(logic [63:0] v, int s);
        return (v << s) | (v >> (64 - s));
    endfunction

    function automatic logic [63:0] mix_lane(logic [63:0] acc, logic [63:0] w);
        return rotl(acc + w * P2, 31) * P1;
    endfunction

    function automatic void clear_state();
        lane[0] = P1 + P2;
        lane[1] = P2;
        lane[2] = '0;
        lane[3] = '0 - P1;
        held_cnt = 0;
        striped = 0;
        msg_len = '0;
    endfunction

    function automatic void predict_digest(logic [63:0] w, logic [3:0] cnt, bit fin);
        int unsigned n;
        logic [63:0] h;
        n = (cnt > 8 || !fin) ? 8 : cnt;
        msg_len += n;
        if (n == 8) begin
            if (held_cnt < 3) begin
                held[held_cnt] = w;
                held_cnt++;
            end else begin
                for (int k = 0; k < 3; k++) lane[k] = mix_lane(lane[k], held[k]);
                lane[3] = mix_lane(lane[3], w);
                striped = 1;
                held_cnt = 0;
            end
            if (!fin) return;
            n = 0;
        end
        if (striped) begin
            h = rotl(lane[0], 1) + rotl(lane[1], 7) + rotl(lane[2], 12) + rotl(lane[3], 18);
            for (int k = 0; k < 4; k++) begin
                h ^= mix_lane('0, lane[k]);
                h = h * P1 + P4;
            end
        end else begin
            h = P5;
        end
        h += msg_len;
        for (int k = 0; k < held_cnt; k++) begin
            h ^= mix_lane('0, held[k]);
            h = rotl(h, 27) * P1 + P4;
        end
        if (n >= 4) begin
            h ^= {32'd0, w[31:0]} * P1;
            h = rotl(h, 23) * P2 + P3;
        end
        for (int k = (n >= 4) ? 4 : 0; k < n; k++) begin
            h ^= {56'd0, w[8*k +: 8]} * P5;
            h = rotl(h, 11) * P1;
        end
        h ^= h >> 33;
        h *= P2;
        h ^= h >> 29;
        h *= P3;
        h ^= h >> 32;
        digest_q.push_back(h);
        clear_state();
    endfunction

    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(logic [63:0] w, logic [3:0] cnt, bit fin, bit gaps = 1);
        int unsigned g;
        g = gaps ? rand_gap() : 0;
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_word <= w;
        i_byte_count <= cnt;
        i_last_word <= fin;
        do @(posedge i_clk); while (o_stall);
        predict_digest(w, cnt, fin);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int unsigned nwords, logic [3:0] tail_cnt, bit gaps = 1);
        for (int k = 0; k < nwords; k++)
            send_word(rand_word(), k == nwords - 1 ? tail_cnt : FULL_BYTES,
                      k == nwords - 1, gaps);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else if (i_rst_n && $urandom_range(0, 99) < 25) begin
            i_stall <= 1'b1;
            if ($urandom_range(0, 19) == 0) hold_cycles = $urandom_range(10, 80);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_q.size() == 0) begin
                $error("unexpected hash_value %h", o_hash_value);
                err_cnt++;
            end else begin
                if (o_hash_value !== digest_q[0]) begin
                    $error("hash_value expected %h actual %h", digest_q[0], o_hash_value);
                    err_cnt++;
                end
                void'(digest_q.pop_front());
            end
        end
        if (cyc > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        send_word(64'h0, 4'd8, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        send_word(64'hA5A5_5A5A_0123_4567, 4'd9, 1'b1);
        for (int c = 1; c < 8; c++) send_word(64'hFFFF_FFFF_FFFF_FFFF, c[3:0], 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0);
        send_word(64'h0, 4'd0, 1'b0);
        send_word(64'h1234, 4'd2, 1'b1);
        send_message(4, 4'd8);
        send_message(4, 4'd3);
        send_message(5, 4'd0);
        send_message(8, 4'd5);
    endtask

    task automatic test_random_messages();
        int unsigned nw;
        logic [3:0] tc;
        while (words_sent < 1000) begin
            nw = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 9);
            tc = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0) begin
                for (int k = 0; k + 1 < nw; k++)
                    send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
                send_word(rand_word(), tc, 1'b1);
            end else begin
                send_message(nw, tc);
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(negedge i_clk);
        hold_cycles = 3000;
        for (int m = 0; m < 8; m++)
            send_message($urandom_range(1, 3), 4'($urandom_range(0, 8)), 1'b0);
        wait_drained();
        repeat (20) @(negedge i_clk);
        for (int m = 0; m < 10; m++)
            send_message($urandom_range(1, 6), 4'($urandom_range(0, 8)), 1'b0);
    endtask

    initial begin
        clear_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_messages();
        test_backpressure();
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (err_cnt == 0 && digest_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/xxh_pkg.sv
hdl/xxh_front.sv
hdl/xxh_mul.sv
hdl/xxh_core.sv
hdl/xxhash64_stream.sv
bench/xxhash64_stream_test.sv
